>>> rtl/bms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types and constants for the bounded multiset table.
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int CMD_W   = 2;
    localparam int CFG_W   = 5;
    localparam int KEY_W   = 32;
    localparam int FIELD_W = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [CFG_W-1:0] CAP_RESET_VALUE = 5'd10;

    typedef struct packed {
        logic               is_empty;
        logic [FIELD_W-1:0] entry_count;
        logic [FIELD_W-1:0] frequency;
        logic               success;
    } bms_result_t;

endpackage
`default_nettype wire

>>> rtl/bounded_multiset_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_multiset_table_top
// Fixed-capacity unordered multiset of keys with add, remove, count, clear.
//
//   Channel  | Dir | Handshake                   | Payload
//   ---------+-----+-----------------------------+------------------------------
//   s_axis   | in  | s_axis_tvalid/s_axis_tready | tuser: command, tdata: key
//   m_axis   | out | m_axis_tvalid/m_axis_tready | tdata: result fields
//   cfg      | in  | cfg_we (no wait)            | cfg_wdata: capacity_limit
//
// One item is in work at a time. The scan reads one stored entry per cycle
// through the entry memory's read port; the engine then finishes the command,
// a remove that hits first moves the last entry into the removed slot, and a
// clear skips the scan and goes straight to the result.
// Reset empties the bag and loads capacity_limit with 10; the entry memory
// is not cleared. A stalled output holds its result in the output register
// while the engine finishes the next item, then waits until the slot frees.
// ----------------------------------------------------------------------------
module bounded_multiset_table_top
    import bms_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [KEY_W-1:0] s_axis_tdata,   // [31:0] key
    input  wire logic [CMD_W-1:0] s_axis_tuser,   // [1:0] command
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [0] success, [5:1] frequency,
                                                  // [10:6] entry_count,
                                                  // [11] is_empty, [15:12] zero
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    logic [CFG_W-1:0]    cap_reg;
    logic                m_valid_reg, m_valid_next;
    bms_result_t         m_res_reg, m_res_next;
    logic                res_valid;
    logic                res_ready;
    bms_result_t         res;
    logic [63:0]         key_wide;
    logic [KEY_BITS-1:0] key_kept;

    // keep only the low KEY_BITS bits of the key; zero-extend when wider
    assign key_wide = {32'd0, s_axis_tdata};
    assign key_kept = key_wide[KEY_BITS-1:0];

    // capacity register; the host must write it only while no item is in flight (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET_VALUE;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    bms_engine #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_key    (key_kept),
        .cap       (cap_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: advance when empty or when the sink takes the result
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready)
        begin
            m_valid_next = res_valid;
            if (res_valid)
            begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, m_res_reg};

    // an empty bag reports no entries and no occurrences
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[10:1] == 10'd0)
        else $error("empty result carries nonzero count or frequency");

    // one item at a time: the engine is busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("engine took a second item while busy");

    // a finished result waits in the engine until the output slot frees
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("engine result dropped or changed while stalled");

endmodule
`default_nettype wire

>>> rtl/bms_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bms_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bms_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/bms_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bms_engine
// Sequencer: scans the held entries one per cycle, then appends, moves the
// last entry into a removed slot, or reports the count; a clear skips the scan and zeroes the count.
// ----------------------------------------------------------------------------
module bms_engine
    import bms_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CMD_W-1:0]    in_cmd,
    input  wire logic [KEY_BITS-1:0] in_key,
    input  wire logic [CFG_W-1:0]    cap,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output bms_result_t              res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_MOVE = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]       held_reg, held_next;
    logic [CW-1:0]       scan_idx_reg, scan_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       first_reg, first_next;
    logic                ok_reg, ok_next;
    logic [CW-1:0]       freq_reg, freq_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_BITS-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [KEY_BITS-1:0] mem_rdata;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;

    logic                issue;
    logic                hit;
    logic                room;
    logic [CW-1:0]       held_dec;
    logic [CMPW-1:0]     freq_ext;
    logic [CMPW-1:0]     held_ext;

    bms_mem #(
        .DEPTH (DEPTH),
        .WIDTH (KEY_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign issue    = scan_idx_reg < held_reg;
    assign hit      = cmp_vld_reg && (mem_rdata == key_reg);
    assign held_dec = held_reg - CW'(1);
    assign room     = (CMPW'(held_reg) < CMPW'(cap)) && (held_reg < CW'(DEPTH));

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);

    assign freq_ext        = CMPW'(freq_reg);
    assign held_ext        = CMPW'(held_reg);
    assign res.success     = ok_reg;
    assign res.frequency   = freq_ext[FIELD_W-1:0];
    assign res.entry_count = held_ext[FIELD_W-1:0];
    assign res.is_empty    = (held_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        held_next     = held_reg;
        scan_idx_next = scan_idx_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = scan_idx_reg[AW-1:0];
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        first_next    = first_reg;
        ok_next       = ok_reg;
        freq_next     = freq_reg;
        mem_we        = 1'b0;
        mem_waddr     = held_reg[AW-1:0];
        mem_wdata     = key_reg;
        mem_re        = 1'b0;
        mem_raddr     = scan_idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = in_cmd;
                    key_next      = in_key;
                    scan_idx_next = '0;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    if (in_cmd == CMD_CLEAR)
                    begin
                        held_next  = '0;
                        ok_next    = 1'b1;
                        freq_next  = '0;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // one read issued, one compare retired per cycle
                mem_re       = issue;
                cmp_vld_next = issue;
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (hit)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    if (!found_reg)
                    begin
                        found_next = 1'b1;
                        first_next = cmp_idx_reg;
                    end
                end
                if (!issue && !cmp_vld_reg)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_RESP;
                unique case (cmd_reg)
                    CMD_ADD:
                    begin
                        ok_next   = room;
                        freq_next = cnt_reg;
                        if (room)
                        begin
                            mem_we    = 1'b1;
                            held_next = held_reg + CW'(1);
                            freq_next = cnt_reg + CW'(1);
                        end
                    end
                    CMD_REMOVE:
                    begin
                        ok_next   = found_reg;
                        freq_next = cnt_reg;
                        if (found_reg)
                        begin
                            // fetch the last entry to fill the hole
                            mem_re     = 1'b1;
                            mem_raddr  = held_dec[AW-1:0];
                            held_next  = held_dec;
                            freq_next  = cnt_reg - CW'(1);
                            state_next = ST_MOVE;
                        end
                    end
                    CMD_COUNT:
                    begin
                        ok_next   = (cnt_reg != '0);
                        freq_next = cnt_reg;
                    end
                    CMD_CLEAR:
                    begin
                        ok_next = 1'b1;
                    end
                endcase
            end
            ST_MOVE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = first_reg;
                mem_wdata  = mem_rdata;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            held_reg    <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        cnt_reg      <= cnt_next;
        found_reg    <= found_next;
        first_reg    <= first_next;
        ok_reg       <= ok_next;
        freq_reg     <= freq_next;
    end

endmodule
`default_nettype wire
